// ===== rtl/core/glu_pkg.sv =====
// Shared types, widths and codes for the gcd / lcm unit.
`default_nettype none

package glu_pkg;

  // Operand width used by the datapath; the port fields keep their own width.
  localparam int VALUE_WIDTH  = 31;
  localparam int FIELD_WIDTH  = 31;
  localparam int RESULT_WIDTH = 62;
  localparam int SHIFT_WIDTH  = $clog2(VALUE_WIDTH);
  localparam int PROD_WIDTH   = 2 * VALUE_WIDTH;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  // Operation codes
  localparam logic ACT_GCD = 1'b0;
  localparam logic ACT_LCM = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [FIELD_WIDTH-1:0] first_value;
    logic [FIELD_WIDTH-1:0] second_value;
  } glu_in_t;

  typedef struct packed {
    logic [RESULT_WIDTH-1:0] result_value;
    logic                    operand_zero;
  } glu_out_t;

  // Classified job handed from front to back
  typedef struct packed {
    logic                   action;
    logic                   operand_zero;
    logic [VALUE_WIDTH-1:0] op_a;
    logic [VALUE_WIDTH-1:0] op_b;
  } glu_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_GCD,
    BK_DIV,
    BK_MUL,
    BK_FIN
  } glu_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/glu_front.sv =====
// Front end: accepts input beats, masks and classifies operands, queues jobs.
`default_nettype none

module glu_front (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_ready,
  input  glu_pkg::glu_in_t   in_data,
  output logic               job_valid,
  input  wire                logic job_ready,
  output glu_pkg::glu_job_t  job_data
);
  import glu_pkg::*;

  glu_job_t               q_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_WIDTH-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_WIDTH-1:0]  count_r, count_nxt;
  glu_job_t               new_job;
  logic                   push, pop;

  // Mask operands to the datapath width and flag a zero operand
  always_comb begin
    new_job.action       = in_data.action;
    new_job.op_a         = VALUE_WIDTH'(in_data.first_value);
    new_job.op_b         = VALUE_WIDTH'(in_data.second_value);
    new_job.operand_zero = (new_job.op_a == '0) || (new_job.op_b == '0);
  end

  assign in_ready  = (count_r != QCNT_WIDTH'(QUEUE_DEPTH));
  assign job_valid = (count_r != '0);
  assign job_data  = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                               : wr_ptr_r + QPTR_WIDTH'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                               : rd_ptr_r + QPTR_WIDTH'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_WIDTH'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_job;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/glu_back.sv =====
// Back end: binary gcd, restoring divide and multiply for lcm, output register.
`default_nettype none

module glu_back (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic job_valid,
  output logic               job_ready,
  input  glu_pkg::glu_job_t  job_data,
  output logic               out_valid,
  input  wire                logic out_ready,
  output glu_pkg::glu_out_t  out_data
);
  import glu_pkg::*;

  glu_state_t              state_r, state_nxt;
  logic [VALUE_WIDTH-1:0]  a_r, a_nxt;
  logic [VALUE_WIDTH-1:0]  b_r, b_nxt;
  logic [VALUE_WIDTH-1:0]  orig_a_r, orig_a_nxt;
  logic [VALUE_WIDTH-1:0]  orig_b_r, orig_b_nxt;
  logic [SHIFT_WIDTH-1:0]  k_r, k_nxt;
  logic [VALUE_WIDTH-1:0]  g_r, g_nxt;
  logic [VALUE_WIDTH-1:0]  rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0]  quot_r, quot_nxt;
  logic [SHIFT_WIDTH-1:0]  cnt_r, cnt_nxt;
  logic                    op_r, op_nxt;
  logic                    zero_r, zero_nxt;
  logic [RESULT_WIDTH-1:0] res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  glu_out_t                out_data_r, out_data_nxt;

  logic [VALUE_WIDTH-1:0]  gcd_w;
  logic [VALUE_WIDTH:0]    rem_sh;
  logic                    q_bit;
  logic [PROD_WIDTH-1:0]   prod;

  assign gcd_w  = a_r << k_r;
  assign rem_sh = {rem_r, quot_r[VALUE_WIDTH-1]};
  assign q_bit  = (rem_sh >= {1'b0, g_r});
  assign prod   = PROD_WIDTH'(quot_r) * PROD_WIDTH'(orig_b_r);

  assign job_ready = (state_r == BK_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    orig_a_nxt    = orig_a_r;
    orig_b_nxt    = orig_b_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    zero_nxt      = zero_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          a_nxt      = job_data.op_a;
          b_nxt      = job_data.op_b;
          orig_a_nxt = job_data.op_a;
          orig_b_nxt = job_data.op_b;
          op_nxt     = job_data.action;
          zero_nxt   = job_data.operand_zero;
          k_nxt      = '0;
          if (job_data.operand_zero) begin
            res_nxt   = '0;
            state_nxt = BK_FIN;
          end else begin
            state_nxt = BK_GCD;
          end
        end
      end

      BK_GCD: begin
        if (a_r == b_r) begin
          g_nxt = gcd_w;
          if (op_r == ACT_LCM) begin
            rem_nxt   = '0;
            quot_nxt  = orig_a_r;
            cnt_nxt   = SHIFT_WIDTH'(VALUE_WIDTH - 1);
            state_nxt = BK_DIV;
          end else begin
            res_nxt   = RESULT_WIDTH'(gcd_w);
            state_nxt = BK_FIN;
          end
        end else if (!a_r[0] && !b_r[0]) begin
          // both even: pull out a common factor of two
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + SHIFT_WIDTH'(1);
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (a_r > b_r) begin
          a_nxt = a_r - b_r;
        end else begin
          b_nxt = b_r - a_r;
        end
      end

      BK_DIV: begin
        // one quotient bit per cycle: orig_a / g
        rem_nxt  = q_bit ? VALUE_WIDTH'(rem_sh - {1'b0, g_r}) : rem_sh[VALUE_WIDTH-1:0];
        quot_nxt = {quot_r[VALUE_WIDTH-2:0], q_bit};
        if (cnt_r == '0) begin
          state_nxt = BK_MUL;
        end else begin
          cnt_nxt = cnt_r - SHIFT_WIDTH'(1);
        end
      end

      BK_MUL: begin
        res_nxt   = RESULT_WIDTH'(prod);
        state_nxt = BK_FIN;
      end

      BK_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_data_nxt.result_value = res_r;
          out_data_nxt.operand_zero = zero_r;
          out_valid_nxt             = 1'b1;
          state_nxt                 = BK_IDLE;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    orig_a_r   <= orig_a_nxt;
    orig_b_r   <= orig_b_nxt;
    k_r        <= k_nxt;
    g_r        <= g_nxt;
    rem_r      <= rem_nxt;
    quot_r     <= quot_nxt;
    cnt_r      <= cnt_nxt;
    op_r       <= op_nxt;
    zero_r     <= zero_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // gcd reduction never drives an operand to zero
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_GCD) |-> (a_r != '0) && (b_r != '0))
    else $error("gcd operand reached zero");

  // divisor is a valid gcd during division
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_DIV) |-> (g_r != '0))
    else $error("divide by zero gcd");

  // zero-operand jobs finish with a zero result
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_FIN) && zero_r |-> (res_r == '0))
    else $error("zero operand gave nonzero result");

  // a taken job leaves idle on the next cycle
  a_job_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE) && job_valid |=> (state_r != BK_IDLE))
    else $error("accepted job not started");

endmodule

`default_nettype wire

// ===== rtl/core/gcd_lcm_unit_core.sv =====
// Top level of the gcd / lcm unit: front end, job queue and back end.
//
// Usage:
//   in_valid / in_ready / in_data carry one beat per job: an action bit
//   (0 = gcd, 1 = lcm) and two unsigned operands. out_valid / out_ready /
//   out_data return one beat per job, in order: the gcd or exact lcm and
//   an operand_zero flag (result 0 when either operand is zero).
// Flow: a beat is written into the job queue, the back end loads the
//   job, then the binary gcd takes one halving or subtract step at a
//   time and ends with a final compare. An lcm adds a restoring
//   division and a multiply step. BK_FIN then moves the result into
//   the output register once it is free. A zero operand skips the
//   arithmetic.
// Back end: one job at a time; job time is set by the gcd step loop
//   and the one-bit-per-cycle divider.
// Reset: rst_n low empties the two-entry job queue, idles the back end
//   and drops out_valid.
// Stall: a held out_ready keeps the result in the output register; the
//   back end waits with the next result and the queue still takes beats
//   until it is full, then in_ready falls.
`default_nettype none

module gcd_lcm_unit_core (
  input  wire               logic clk,
  input  wire               logic rst_n,
  input  wire               logic in_valid,
  output logic              in_ready,
  input  glu_pkg::glu_in_t  in_data,
  output logic              out_valid,
  input  wire               logic out_ready,
  output glu_pkg::glu_out_t out_data
);
  import glu_pkg::*;

  logic     job_valid;
  logic     job_ready;
  glu_job_t job_data;

  glu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_data  (job_data)
  );

  glu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_data  (job_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the gcd / lcm unit: table-driven and random jobs.
`timescale 1ns / 100ps

module tb;
  import glu_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_JOBS  = 500;   // per flow-control phase
  localparam int PRINT_LIMIT  = 40;
  localparam logic [FIELD_WIDTH-1:0] MAX_OP = '1;

  typedef struct {
    glu_in_t  beat;
    bit       typed;
    glu_out_t want;
  } job_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  glu_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  glu_out_t out_data;

  glu_out_t pending_results[$];
  job_row_t job_table[$];

  int src_idle_pct;
  int sink_stall_pct;
  int mismatch_count;
  int results_checked;
  int jobs_sent;
  int lcm_jobs;
  int zero_jobs;
  int cycle_count;

  gcd_lcm_unit_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact gcd by Euclid, lcm as (a / gcd) * b at 64 bits, low 62 bits kept
  function automatic glu_out_t gcd_lcm_of(input glu_in_t beat);
    logic [63:0] mask;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    logic [63:0] lcm;
    glu_out_t    res;
    mask = (64'd1 << VALUE_WIDTH) - 64'd1;
    a = beat.first_value;
    b = beat.second_value;
    a = a & mask;
    b = b & mask;
    res = '0;
    if (a == 64'd0 || b == 64'd0) begin
      res.operand_zero = 1'b1;
    end else begin
      x = a;
      y = b;
      while (y != 64'd0) begin
        r = x % y;
        x = y;
        y = r;
      end
      if (beat.action == ACT_GCD) begin
        res.result_value = x[RESULT_WIDTH-1:0];
      end else begin
        lcm = (a / x) * b;
        res.result_value = lcm[RESULT_WIDTH-1:0];
      end
    end
    return res;
  endfunction

  task automatic add_row(input logic act, input logic [FIELD_WIDTH-1:0] a,
                         input logic [FIELD_WIDTH-1:0] b, input bit typed,
                         input logic [RESULT_WIDTH-1:0] res, input logic zf);
    job_row_t row;
    row.beat.action       = act;
    row.beat.first_value  = a;
    row.beat.second_value = b;
    row.typed             = typed;
    row.want.result_value = res;
    row.want.operand_zero = zf;
    job_table.push_back(row);
  endtask

  // Mix of operand shapes: full-range, shared factors, equal, small, shifted odd values, zeros, ones
  function automatic glu_in_t random_job();
    glu_in_t     beat;
    int unsigned g;
    int unsigned pick;
    beat.action       = ($urandom_range(1) != 0) ? ACT_LCM : ACT_GCD;
    beat.first_value  = FIELD_WIDTH'($urandom());
    beat.second_value = FIELD_WIDTH'($urandom());
    pick = $urandom_range(99);
    if (pick < 5) begin
      if ($urandom_range(1) != 0) beat.first_value = '0;
      if ($urandom_range(1) != 0) beat.second_value = '0;
    end else if (pick < 40) begin
      // keep the full-range operands as drawn
    end else if (pick < 62) begin
      g = $urandom_range(65535, 1);
      beat.first_value  = FIELD_WIDTH'(g * $urandom_range(MAX_OP / g, 1));
      beat.second_value = FIELD_WIDTH'(g * $urandom_range(MAX_OP / g, 1));
    end else if (pick < 72) begin
      beat.second_value = beat.first_value;
    end else if (pick < 84) begin
      beat.first_value  = FIELD_WIDTH'($urandom_range(255, 1));
      beat.second_value = FIELD_WIDTH'($urandom_range(255, 1));
    end else if (pick < 94) begin
      beat.first_value  = FIELD_WIDTH'((beat.first_value | 1) << $urandom_range(30));
      beat.second_value = FIELD_WIDTH'((beat.second_value | 1) << $urandom_range(30));
    end else begin
      if ($urandom_range(1) != 0) beat.first_value = 1;
      else beat.second_value = 1;
    end
    return beat;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Offer one beat, hold it until taken, then queue its expected result
  task automatic send_job(input glu_in_t beat, input glu_out_t want);
    int gap;
    if ($urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(6, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(want);
    jobs_sent++;
    if (beat.action == ACT_LCM) lcm_jobs++;
    if (want.operand_zero) zero_jobs++;
  endtask

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Check each result beat against the oldest pending expectation
  always @(posedge clk) begin
    glu_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", 64'(out_data.result_value),
                        '0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.result_value !== want.result_value) begin
          report_mismatch("result_value", 64'(out_data.result_value),
                          64'(want.result_value));
        end
        if (out_data.operand_zero !== want.operand_zero) begin
          report_mismatch("operand_zero", 64'(out_data.operand_zero),
                          64'(want.operand_zero));
        end
        results_checked++;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, pending_results.size());
      $display("gcd_lcm_unit_core regression: fail");
      $finish;
    end
  end

  initial begin
    int phase;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    src_idle_pct   = 17;
    sink_stall_pct = 57;

    // zero operands, extremes, coprime, equal, shared-factor and power-of-two operands
    add_row(ACT_GCD, 0, 0, 1, 0, 1'b1);
    add_row(ACT_LCM, 0, 5, 1, 0, 1'b1);
    add_row(ACT_GCD, MAX_OP, 0, 1, 0, 1'b1);
    add_row(ACT_LCM, 0, MAX_OP, 1, 0, 1'b1);
    add_row(ACT_GCD, 1, 1, 1, 1, 1'b0);
    add_row(ACT_LCM, 1, 1, 1, 1, 1'b0);
    add_row(ACT_GCD, MAX_OP, MAX_OP, 1, MAX_OP, 1'b0);
    add_row(ACT_LCM, MAX_OP, MAX_OP, 1, MAX_OP, 1'b0);
    add_row(ACT_GCD, 1, MAX_OP, 1, 1, 1'b0);
    add_row(ACT_LCM, 1, MAX_OP, 1, MAX_OP, 1'b0);
    add_row(ACT_GCD, MAX_OP, MAX_OP - 31'd1, 1, 1, 1'b0);
    add_row(ACT_LCM, MAX_OP, MAX_OP - 31'd1, 0, 0, 1'b0);
    add_row(ACT_GCD, 12, 18, 1, 6, 1'b0);
    add_row(ACT_LCM, 12, 18, 1, 36, 1'b0);
    add_row(ACT_GCD, 31'h4000_0000, 31'h2000_0000, 1, 62'h2000_0000, 1'b0);
    add_row(ACT_LCM, 31'h4000_0000, 31'h3fff_ffff, 0, 0, 1'b0);
    add_row(ACT_GCD, 48, 180, 0, 0, 1'b0);
    add_row(ACT_LCM, 1234567, 7654321, 0, 0, 1'b0);
    add_row(ACT_GCD, 31'h5555_5555, 31'h2aaa_aaaa, 0, 0, 1'b0);
    add_row(ACT_LCM, 31'h2aaa_aaaa, 31'h5555_5555, 0, 0, 1'b0);
    add_row(ACT_LCM, 31'h4000_0000, 3, 0, 0, 1'b0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the table, then random jobs under each flow-control mix
    foreach (job_table[i]) begin
      send_job(job_table[i].beat,
               job_table[i].typed ? job_table[i].want : gcd_lcm_of(job_table[i].beat));
    end
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 17; sink_stall_pct = 57; end
        1: begin src_idle_pct = 57; sink_stall_pct = 17; end
        default: begin src_idle_pct = 0; sink_stall_pct = 0; end
      endcase
      repeat (RANDOM_JOBS) begin
        glu_in_t beat;
        beat = random_job();
        send_job(beat, gcd_lcm_of(beat));
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d jobs (%0d from the table, %0d lcm, %0d with a zero operand)",
             jobs_sent, job_table.size(), lcm_jobs, zero_jobs);
    $display("checked %0d results, %0d mismatches, %0d cycles",
             results_checked, mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("gcd_lcm_unit_core regression: pass");
    end else begin
      $display("gcd_lcm_unit_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== gcd_lcm_unit_core.f =====
rtl/core/glu_pkg.sv
rtl/core/glu_front.sv
rtl/core/glu_back.sv
rtl/core/gcd_lcm_unit_core.sv
sim/tb.sv
